// ===== rtl/core/ffha_pkg.sv =====
// Shared codes, defaults and field widths of the first-fit heap allocator.
package ffha_pkg;

	localparam int HEAP_BYTES_DEF  = 65536;
	localparam int ALIGN_BYTES_DEF = 8;
	localparam int MIN_POOL        = 48;

	localparam int TYPE_W  = 2;
	localparam int BYTES_W = 17;
	localparam int OFF_W   = 16;
	localparam int STAT_W  = 2;

	localparam logic [BYTES_W-1:0] CNT_MAX = 17'h1FFFF;

	localparam logic [TYPE_W-1:0] REQ_ALLOC = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_FREE  = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_OOM  = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;
	localparam logic [STAT_W-1:0] ST_ZERO = 2'd3;

endpackage

// ===== rtl/core/first_fit_heap_allocator.sv =====
// First-fit heap allocator: address-ordered free list held in a header memory.
//
// Requests come in on the in_valid/in_stall channel (req_type, req_bytes,
// block_offset); one result word per request leaves on out_valid/out_stall.
// Only one request is in work at a time; in_stall is high from acceptance
// until the result has been moved into the output register.
// Each request passes the divider states S_DIV_A and S_DIV_B first. A query
// then reads the block header; allocate walks the free list and drains up
// to 3 header writes; free reads the block header, divides its size, walks
// the free list and drains up to 2 header writes. Rejected requests (bad
// offset or type) go straight to the result. The free-list walk reads one
// header per block through the header memory (registered read, own write
// port) and checks it in the state that follows.
// A new request can be accepted while a finished result still waits in the
// output register; the next result then waits in its last state until the
// receiver lowers out_stall.
// Reset, and every pool-size write on cfg_wr_en, starts a clearing pass over
// all HEAP_BYTES/ALIGN_BYTES header entries, one per cycle (a written pool
// size is first rounded in S_CFG_A and S_CFG_B); in_stall stays high throughout.
module first_fit_heap_allocator #(
	parameter int HEAP_BYTES  = ffha_pkg::HEAP_BYTES_DEF,
	parameter int ALIGN_BYTES = ffha_pkg::ALIGN_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [ffha_pkg::BYTES_W-1:0]  cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ffha_pkg::TYPE_W-1:0]   req_type,
	input  logic [ffha_pkg::BYTES_W-1:0]  req_bytes,
	input  logic [ffha_pkg::OFF_W-1:0]    block_offset,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ffha_pkg::STAT_W-1:0]   status,
	output logic [ffha_pkg::OFF_W-1:0]    result_offset,
	output logic [ffha_pkg::BYTES_W-1:0]  block_bytes,
	output logic [ffha_pkg::BYTES_W-1:0]  free_bytes,
	output logic [ffha_pkg::BYTES_W-1:0]  min_free_bytes
);

	localparam int HEAP_UNITS = HEAP_BYTES / ALIGN_BYTES;
	localparam int UW   = (HEAP_UNITS > 2) ? $clog2(HEAP_UNITS) : 1;
	localparam int SW   = $clog2(HEAP_UNITS + 2);
	localparam int SZW  = ffha_pkg::BYTES_W;
	localparam int BW   = (($clog2(HEAP_BYTES) > 18) ? $clog2(HEAP_BYTES) : 18) + 2;
	localparam int DXW  = 18;
	localparam int DSH  = DXW + 1;
	localparam int POOL_CAP = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;
	localparam int POOL_RST = (POOL_CAP / ALIGN_BYTES) * ALIGN_BYTES;

	localparam logic [DSH-1:0] RECIP   = DSH'((2 ** DSH) / ALIGN_BYTES);
	localparam logic [BW-1:0]  A_B     = BW'(ALIGN_BYTES);
	localparam logic [BW-1:0]  UNITS_B = BW'(HEAP_UNITS);
	localparam logic [BW-1:0]  MINBLK  = BW'(2 * ALIGN_BYTES);
	localparam logic [BW-1:0]  MINPOOL = BW'(ffha_pkg::MIN_POOL);
	localparam logic [BW-1:0]  HEAP_B  = BW'(HEAP_BYTES);

	localparam logic [4:0] S_CLEAR = 5'd0;
	localparam logic [4:0] S_CFG_A = 5'd1;
	localparam logic [4:0] S_CFG_B = 5'd2;
	localparam logic [4:0] S_IDLE  = 5'd3;
	localparam logic [4:0] S_DIV_A = 5'd4;
	localparam logic [4:0] S_DIV_B = 5'd5;
	localparam logic [4:0] S_A_RD  = 5'd6;
	localparam logic [4:0] S_A_CHK = 5'd7;
	localparam logic [4:0] S_H_RD  = 5'd8;
	localparam logic [4:0] S_H_CHK = 5'd9;
	localparam logic [4:0] S_F_DA  = 5'd10;
	localparam logic [4:0] S_F_DB  = 5'd11;
	localparam logic [4:0] S_F_RD  = 5'd12;
	localparam logic [4:0] S_F_CHK = 5'd13;
	localparam logic [4:0] S_N_RD  = 5'd14;
	localparam logic [4:0] S_N_CHK = 5'd15;
	localparam logic [4:0] S_WR    = 5'd16;
	localparam logic [4:0] S_DONE  = 5'd17;

	typedef struct packed {
		logic [UW-1:0]  next;
		logic           link;
		logic [SZW-1:0] size;
	} hdr_t;

	typedef struct packed {
		logic          vld;
		logic [UW-1:0] addr;
		hdr_t          data;
	} wslot_t;

	hdr_t hdr_mem [HEAP_UNITS];
	hdr_t mem_rd_q;
	logic           mem_we;
	logic [UW-1:0]  mem_waddr;
	hdr_t           mem_wdata;

	logic [4:0]     state_q;
	logic [UW-1:0]  addr_q;
	logic [UW-1:0]  clr_cnt_q;
	logic [SZW-1:0] pool_q;
	logic [UW-1:0]  free_head_q;
	logic           head_valid_q;
	logic [SZW-1:0] total_q;
	logic [SZW-1:0] lowest_q;

	logic [ffha_pkg::TYPE_W-1:0]  type_q;
	logic [ffha_pkg::BYTES_W-1:0] req_q;
	logic [ffha_pkg::OFF_W-1:0]   off_q;
	logic [DXW-1:0] div_x_q;
	logic [DXW-1:0] q0_q;
	logic [BW-1:0]  nu_q;
	logic [BW-1:0]  need_q;
	logic [UW-1:0]  cur_q;
	logic [UW-1:0]  prev_q;
	hdr_t           prev_hdr_q;
	logic           has_prev_q;
	logic [SW-1:0]  steps_q;
	logic [UW-1:0]  b_q;
	logic [BW-1:0]  bs_q;
	hdr_t           bh_q;
	hdr_t           ch_q;
	wslot_t         slot0_q, slot1_q, slot2_q;

	logic [ffha_pkg::STAT_W-1:0]  res_stat_q;
	logic [ffha_pkg::OFF_W-1:0]   res_off_q;
	logic [ffha_pkg::BYTES_W-1:0] res_bytes_q;

	logic                         out_valid_q;
	logic                         out_load;
	logic [ffha_pkg::STAT_W-1:0]  out_stat_q;
	logic [ffha_pkg::OFF_W-1:0]   out_off_q;
	logic [ffha_pkg::BYTES_W-1:0] out_bytes_q;
	logic [ffha_pkg::BYTES_W-1:0] out_free_q;
	logic [ffha_pkg::BYTES_W-1:0] out_min_q;

	// constant divider by ALIGN_BYTES: reciprocal product, then one correction
	logic [DXW+DSH-1:0] div_prod;
	logic [DXW-1:0]     rem0;
	logic               div_fix;
	logic [DXW-1:0]     div_q;
	logic [DXW-1:0]     div_r;

	always_comb begin
		div_prod = (DXW+DSH)'(div_x_q) * (DXW+DSH)'(RECIP);
		rem0     = div_x_q - DXW'(q0_q * DXW'(ALIGN_BYTES));
		div_fix  = (rem0 >= DXW'(ALIGN_BYTES));
		div_q    = q0_q + DXW'(div_fix);
		div_r    = div_fix ? (rem0 - DXW'(ALIGN_BYTES)) : rem0;
	end

	// allocation walk
	hdr_t          h;
	logic [BW-1:0] h_size_b;
	logic [BW-1:0] cur_b;
	logic [BW-1:0] nb_b;
	logic          fits;
	logic          split;
	logic [SW-1:0] steps_nx;

	// free walk
	hdr_t          fch;
	logic [BW-1:0] bsz_b;
	logic [BW-1:0] bend;
	logic [BW-1:0] cs;
	logic [BW-1:0] cend;
	logic [BW-1:0] ns;
	logic          bs_le_cl;
	logic          joins_prev;
	logic [BW-1:0] pool_rnd;
	logic          off_ok;

	always_comb begin
		h        = mem_rd_q;
		h_size_b = BW'(h.size);
		cur_b    = BW'(cur_q);
		nb_b     = cur_b + nu_q;
		fits     = (h_size_b >= need_q);
		split    = ((h_size_b - need_q) >= MINBLK) && (nb_b < UNITS_B);
		steps_nx = steps_q + SW'(1);
		fch      = (state_q == S_N_CHK) ? ch_q : mem_rd_q;
		bsz_b    = BW'(bh_q.size);
		bend     = bs_q + bsz_b;
		cs       = cur_b * A_B;
		cend     = cs + BW'(fch.size);
		ns       = BW'(fch.next) * A_B;
		bs_le_cl = (cend < A_B) || ((bs_q + A_B) <= cend);
		joins_prev = (bs_q == cend);
		pool_rnd = BW'(div_q) * A_B;
		off_ok   = (BW'(off_q) >= A_B) && (div_r == '0) &&
			(BW'(div_x_q) < BW'(pool_q)) && (BW'(div_q) < UNITS_B);
		out_load = !cfg_wr_en && (state_q == S_DONE) && (!out_valid_q || !out_stall);
	end

	function automatic logic [SZW-1:0] sat_sub(input logic [SZW-1:0] t,
		input logic [BW-1:0] n);
		if (n > BW'(t))
			return '0;
		return SZW'(BW'(t) - n);
	endfunction

	function automatic logic [SZW-1:0] sat_add(input logic [SZW-1:0] t,
		input logic [BW-1:0] n);
		if ((BW'(t) + n) > BW'(ffha_pkg::CNT_MAX))
			return ffha_pkg::CNT_MAX;
		return SZW'(BW'(t) + n);
	endfunction

	function automatic logic [SZW-1:0] min_sz(input logic [SZW-1:0] a,
		input logic [SZW-1:0] b);
		return (a < b) ? a : b;
	endfunction

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_cnt_q;
		mem_wdata = '0;
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
			if (clr_cnt_q == '0)
				mem_wdata.size = pool_q;
		end else if (state_q == S_WR) begin
			if (slot0_q.vld) begin
				mem_we    = 1'b1;
				mem_waddr = slot0_q.addr;
				mem_wdata = slot0_q.data;
			end else if (slot1_q.vld) begin
				mem_we    = 1'b1;
				mem_waddr = slot1_q.addr;
				mem_wdata = slot1_q.data;
			end else if (slot2_q.vld) begin
				mem_we    = 1'b1;
				mem_waddr = slot2_q.addr;
				mem_wdata = slot2_q.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			hdr_mem[mem_waddr] <= mem_wdata;
		mem_rd_q <= hdr_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		q0_q <= div_prod[DSH +: DXW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			addr_q       <= '0;
			clr_cnt_q    <= '0;
			pool_q       <= SZW'(POOL_RST);
			free_head_q  <= '0;
			head_valid_q <= 1'b1;
			total_q      <= SZW'(POOL_RST);
			lowest_q     <= SZW'(POOL_RST);
			slot0_q.vld  <= 1'b0;
			slot1_q.vld  <= 1'b0;
			slot2_q.vld  <= 1'b0;
			has_prev_q   <= 1'b0;
			steps_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			if (cfg_wr_en) begin
				div_x_q <= (BW'(cfg_wr_data) > HEAP_B) ? DXW'(HEAP_BYTES) : DXW'(cfg_wr_data);
				state_q <= S_CFG_A;
			end else begin
				unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + UW'(1);
					if (BW'(clr_cnt_q) == UNITS_B - BW'(1))
						state_q <= S_IDLE;
				end
				S_CFG_A: state_q <= S_CFG_B;
				S_CFG_B: begin
					pool_q       <= (pool_rnd < MINPOOL) ? SZW'(MINPOOL) : SZW'(pool_rnd);
					total_q      <= (pool_rnd < MINPOOL) ? SZW'(MINPOOL) : SZW'(pool_rnd);
					lowest_q     <= (pool_rnd < MINPOOL) ? SZW'(MINPOOL) : SZW'(pool_rnd);
					free_head_q  <= '0;
					head_valid_q <= 1'b1;
					clr_cnt_q    <= '0;
					state_q      <= S_CLEAR;
				end
				S_IDLE: begin
					if (in_valid) begin
						type_q      <= req_type;
						req_q       <= req_bytes;
						off_q       <= block_offset;
						res_off_q   <= '0;
						res_bytes_q <= '0;
						slot0_q.vld <= 1'b0;
						slot1_q.vld <= 1'b0;
						slot2_q.vld <= 1'b0;
						if (req_type == ffha_pkg::REQ_ALLOC)
							div_x_q <= DXW'(req_bytes) + DXW'(ALIGN_BYTES - 1);
						else
							div_x_q <= DXW'(block_offset) - DXW'(ALIGN_BYTES);
						state_q <= S_DIV_A;
					end
				end
				S_DIV_A: state_q <= S_DIV_B;
				S_DIV_B: begin
					has_prev_q <= 1'b0;
					steps_q    <= '0;
					unique case (type_q) inside
					ffha_pkg::REQ_ALLOC: begin
						nu_q   <= BW'(div_q) + BW'(1);
						need_q <= (BW'(div_q) + BW'(1)) * A_B;
						cur_q  <= free_head_q;
						addr_q <= free_head_q;
						if (req_q == '0) begin
							res_stat_q <= ffha_pkg::ST_ZERO;
							state_q    <= S_DONE;
						end else if (!head_valid_q || BW'(free_head_q) >= UNITS_B) begin
							res_stat_q <= ffha_pkg::ST_OOM;
							state_q    <= S_DONE;
						end else begin
							state_q <= S_A_RD;
						end
					end
					ffha_pkg::REQ_FREE, ffha_pkg::REQ_QUERY: begin
						b_q    <= UW'(div_q);
						addr_q <= UW'(div_q);
						bs_q   <= BW'(div_x_q);
						if (off_ok) begin
							state_q <= S_H_RD;
						end else begin
							res_stat_q <= ffha_pkg::ST_BAD;
							state_q    <= S_DONE;
						end
					end
					default: begin
						res_stat_q <= ffha_pkg::ST_BAD;
						state_q    <= S_DONE;
					end
					endcase
				end
				S_A_RD: state_q <= S_A_CHK;
				S_A_CHK: begin
					if (fits) begin
						slot0_q.vld  <= split;
						slot0_q.addr <= UW'(nb_b);
						slot0_q.data <= '{next: h.next, link: h.link,
							size: SZW'(h_size_b - need_q)};
						slot1_q.vld  <= has_prev_q;
						slot1_q.addr <= prev_q;
						slot1_q.data <= '{next: split ? UW'(nb_b) : h.next,
							link: split | h.link, size: prev_hdr_q.size};
						if (!has_prev_q) begin
							free_head_q  <= split ? UW'(nb_b) : h.next;
							head_valid_q <= split | h.link;
						end
						slot2_q.vld  <= 1'b1;
						slot2_q.addr <= cur_q;
						slot2_q.data <= '{next: '0, link: 1'b0,
							size: split ? SZW'(need_q) : h.size};
						total_q  <= sat_sub(total_q, split ? need_q : h_size_b);
						lowest_q <= min_sz(lowest_q,
							sat_sub(total_q, split ? need_q : h_size_b));
						res_off_q  <= ffha_pkg::OFF_W'(cs + A_B);
						res_stat_q <= ffha_pkg::ST_OK;
						state_q    <= S_WR;
					end else begin
						prev_q     <= cur_q;
						prev_hdr_q <= h;
						has_prev_q <= 1'b1;
						cur_q      <= h.next;
						addr_q     <= h.next;
						steps_q    <= steps_nx;
						if (!h.link || BW'(h.next) >= UNITS_B || BW'(steps_nx) > UNITS_B) begin
							res_stat_q <= ffha_pkg::ST_OOM;
							state_q    <= S_DONE;
						end else begin
							state_q <= S_A_RD;
						end
					end
				end
				S_H_RD: state_q <= S_H_CHK;
				S_H_CHK: begin
					if (type_q == ffha_pkg::REQ_QUERY) begin
						res_bytes_q <= h.size;
						res_stat_q  <= ffha_pkg::ST_OK;
						state_q     <= S_DONE;
					end else begin
						bh_q    <= h;
						div_x_q <= DXW'(h.size);
						state_q <= S_F_DA;
					end
				end
				S_F_DA: state_q <= S_F_DB;
				S_F_DB: begin
					cur_q  <= free_head_q;
					addr_q <= free_head_q;
					if (div_r != '0 || bsz_b < MINBLK || bh_q.link || bend > BW'(pool_q)) begin
						res_stat_q <= ffha_pkg::ST_BAD;
						state_q    <= S_DONE;
					end else if (!head_valid_q) begin
						free_head_q  <= b_q;
						head_valid_q <= 1'b1;
						total_q      <= sat_add(total_q, bsz_b);
						res_stat_q   <= ffha_pkg::ST_OK;
						state_q      <= S_DONE;
					end else if (BW'(free_head_q) >= UNITS_B) begin
						res_stat_q <= ffha_pkg::ST_BAD;
						state_q    <= S_DONE;
					end else begin
						state_q <= S_F_RD;
					end
				end
				S_F_RD: state_q <= S_F_CHK;
				S_F_CHK: begin
					ch_q <= fch;
					if (bs_q < cs) begin
						if (bend >= cs + A_B) begin
							res_stat_q <= ffha_pkg::ST_BAD;
							state_q    <= S_DONE;
						end else begin
							slot0_q.vld  <= 1'b1;
							slot0_q.addr <= b_q;
							if (bend == cs)
								slot0_q.data <= '{next: fch.next, link: fch.link,
									size: SZW'(bsz_b + BW'(fch.size))};
							else
								slot0_q.data <= '{next: cur_q, link: 1'b1, size: bh_q.size};
							slot1_q.vld  <= has_prev_q;
							slot1_q.addr <= prev_q;
							slot1_q.data <= '{next: b_q, link: 1'b1, size: prev_hdr_q.size};
							if (!has_prev_q) begin
								free_head_q  <= b_q;
								head_valid_q <= 1'b1;
							end
							total_q    <= sat_add(total_q, bsz_b);
							res_stat_q <= ffha_pkg::ST_OK;
							state_q    <= S_WR;
						end
					end else if (bs_q == cs || bs_le_cl) begin
						res_stat_q <= ffha_pkg::ST_BAD;
						state_q    <= S_DONE;
					end else if (fch.link) begin
						addr_q <= fch.next;
						if (BW'(fch.next) >= UNITS_B) begin
							res_stat_q <= ffha_pkg::ST_BAD;
							state_q    <= S_DONE;
						end else if (bs_q < ns) begin
							if (bend >= ns + A_B) begin
								res_stat_q <= ffha_pkg::ST_BAD;
								state_q    <= S_DONE;
							end else begin
								state_q <= S_N_RD;
							end
						end else begin
							prev_q     <= cur_q;
							prev_hdr_q <= fch;
							has_prev_q <= 1'b1;
							cur_q      <= fch.next;
							steps_q    <= steps_nx;
							if (BW'(steps_nx) > UNITS_B) begin
								res_stat_q <= ffha_pkg::ST_BAD;
								state_q    <= S_DONE;
							end else begin
								state_q <= S_F_RD;
							end
						end
					end else begin
						// tail of the list: grow it or append behind it
						if (joins_prev) begin
							slot0_q.vld  <= 1'b1;
							slot0_q.addr <= cur_q;
							slot0_q.data <= '{next: fch.next, link: fch.link,
								size: SZW'(BW'(fch.size) + bsz_b)};
						end else begin
							slot0_q.vld  <= 1'b1;
							slot0_q.addr <= b_q;
							slot0_q.data <= '{next: '0, link: 1'b0, size: bh_q.size};
							slot1_q.vld  <= 1'b1;
							slot1_q.addr <= cur_q;
							slot1_q.data <= '{next: b_q, link: 1'b1, size: fch.size};
						end
						total_q    <= sat_add(total_q, bsz_b);
						res_stat_q <= ffha_pkg::ST_OK;
						state_q    <= S_WR;
					end
				end
				S_N_RD: state_q <= S_N_CHK;
				S_N_CHK: begin
					if (bend == ns) begin
						if (joins_prev) begin
							// bridge the preceding and following free blocks
							slot0_q.vld  <= 1'b1;
							slot0_q.addr <= cur_q;
							slot0_q.data <= '{next: h.next, link: h.link,
								size: SZW'(BW'(ch_q.size) + bsz_b + h_size_b)};
						end else begin
							slot0_q.vld  <= 1'b1;
							slot0_q.addr <= b_q;
							slot0_q.data <= '{next: h.next, link: h.link,
								size: SZW'(bsz_b + h_size_b)};
							slot1_q.vld  <= 1'b1;
							slot1_q.addr <= cur_q;
							slot1_q.data <= '{next: b_q, link: ch_q.link, size: ch_q.size};
						end
					end else if (joins_prev) begin
						slot0_q.vld  <= 1'b1;
						slot0_q.addr <= cur_q;
						slot0_q.data <= '{next: ch_q.next, link: ch_q.link,
							size: SZW'(BW'(ch_q.size) + bsz_b)};
					end else begin
						slot0_q.vld  <= 1'b1;
						slot0_q.addr <= b_q;
						slot0_q.data <= '{next: ch_q.next, link: 1'b1, size: bh_q.size};
						slot1_q.vld  <= 1'b1;
						slot1_q.addr <= cur_q;
						slot1_q.data <= '{next: b_q, link: ch_q.link, size: ch_q.size};
					end
					total_q    <= sat_add(total_q, bsz_b);
					res_stat_q <= ffha_pkg::ST_OK;
					state_q    <= S_WR;
				end
				S_WR: begin
					// drain pending header writes in order, one per cycle
					if (slot0_q.vld)
						slot0_q.vld <= 1'b0;
					else if (slot1_q.vld)
						slot1_q.vld <= 1'b0;
					else if (slot2_q.vld)
						slot2_q.vld <= 1'b0;
					else
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_stat_q  <= res_stat_q;
						out_off_q   <= res_off_q;
						out_bytes_q <= res_bytes_q;
						out_free_q  <= total_q;
						out_min_q   <= lowest_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign in_stall       = (state_q != S_IDLE);
	assign out_valid      = out_valid_q;
	assign status         = out_stat_q;
	assign result_offset  = out_off_q;
	assign block_bytes    = out_bytes_q;
	assign free_bytes     = out_free_q;
	assign min_free_bytes = out_min_q;

endmodule

// ===== rtl/core/ffha_checker.sv =====
// Port-level checks of the first-fit heap allocator, bound to its top level.
module ffha_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_wr_en,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [ffha_pkg::STAT_W-1:0]   status,
	input logic [ffha_pkg::OFF_W-1:0]    result_offset,
	input logic [ffha_pkg::BYTES_W-1:0]  block_bytes,
	input logic [ffha_pkg::BYTES_W-1:0]  free_bytes,
	input logic [ffha_pkg::BYTES_W-1:0]  min_free_bytes
);

	// a stalled result word holds its status, offset and free count
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
		$stable(result_offset) && $stable(free_bytes))
		else $error("stalled result word changed");

	// one request in work at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while another is in work");

	// a pool write holds off new requests while the heap is rebuilt
	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> in_stall)
		else $error("request channel open right after a pool write");

	a_low_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> min_free_bytes <= free_bytes)
		else $error("lowest free count above free count");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ffha_pkg::ST_OK |-> result_offset == '0 && block_bytes == '0)
		else $error("failed request reports an offset or size");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);
